>>> hdl/sbte_pkg.sv
`default_nettype none

package sbte_pkg;

  // s_axis_tuser selector
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_LINE    = 2'd2;

  // m_axis_tuser kind
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // completion status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LINE     = 3'd1;
  localparam logic [2:0] ST_ECHO     = 3'd2;
  localparam logic [2:0] ST_PROTOCOL = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [7:0] INSTR_READ   = 8'h02;

  // header, id, length, instruction/error and checksum
  localparam int unsigned FRAME_OVERHEAD = 6;

  localparam int unsigned LEN_W   = 9;  // byte counts up to 270
  localparam int unsigned ECHO_W  = 4;  // packet size up to 9
  localparam int unsigned IN_W    = 56;
  localparam int unsigned OUT_W   = 48;

endpackage

`default_nettype wire

>>> hdl/servo_bus_transaction_engine.sv
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser op; tdata request, rx byte, line flags
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser kind; tlast end of packet; tdata result
//
// Received bytes and line events are each taken as one input item; a completion is
// registered in the same cycle that the closing item is accepted.
// A request of n argument bytes ties up the output while its 6 + n byte packet is read out
// of the packet register file, one byte per cycle unless stalled; no input is taken then.
// Reset clears the transaction state and the output valid flag; the block starts idle.
// A stalled output holds its item; input is still taken while the output register
// is being emptied in the same cycle.
module servo_bus_transaction_engine #(
  parameter int unsigned MAX_ARGS    = 3,
  parameter int unsigned DRAIN_BYTES = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // servo_id, instruction, arg_count, arg_first, arg_second, arg_third,
  // rx_value, line_flags, 2 bits zero fill
  input  wire logic [sbte_pkg::IN_W-1:0]     s_axis_tdata,
  // op
  input  wire logic [1:0]                    s_axis_tuser,

  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tx_value, status, line_status, device_error, data_low, data_high,
  // data_count, 7 bits zero fill
  output      logic [sbte_pkg::OUT_W-1:0]    m_axis_tdata,
  // tx_last
  output      logic                          m_axis_tlast,
  // kind
  output      logic                          m_axis_tuser
);

  localparam int unsigned PktDepth = 6 + MAX_ARGS;
  localparam int unsigned IdxW     = $clog2(PktDepth);
  localparam int unsigned ArgLim   = (MAX_ARGS < 3) ? MAX_ARGS : 3;
  localparam int unsigned DcW      = $clog2(DRAIN_BYTES + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RECV  = 2'd1;
  localparam logic [1:0] PH_DRAIN = 2'd2;

  function automatic logic [7:0] arg_sel(input int idx, input logic [7:0] a0,
                                         input logic [7:0] a1, input logic [7:0] a2);
    logic [7:0] v;
    case (idx)
      0:       v = a0;
      1:       v = a1;
      2:       v = a2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // input fields
  logic [7:0] in_id, in_instr, in_a0, in_a1, in_a2, in_rx;
  logic [1:0] in_argc_raw, in_argc;
  logic [3:0] in_flags;

  assign in_id       = s_axis_tdata[7:0];
  assign in_instr    = s_axis_tdata[15:8];
  assign in_argc_raw = s_axis_tdata[17:16];
  assign in_a0       = s_axis_tdata[25:18];
  assign in_a1       = s_axis_tdata[33:26];
  assign in_a2       = s_axis_tdata[41:34];
  assign in_rx       = s_axis_tdata[49:42];
  assign in_flags    = s_axis_tdata[53:50];

  assign in_argc = (in_argc_raw > 2'(ArgLim)) ? 2'(ArgLim) : in_argc_raw;

  // state
  logic [1:0]                   phase_q, phase_d;
  logic [7:0]                   pkt_q [PktDepth];
  logic [7:0]                   pkt_d [PktDepth];
  logic                         tx_busy_q, tx_busy_d;
  logic [IdxW-1:0]              tx_idx_q, tx_idx_d;
  logic [sbte_pkg::ECHO_W-1:0]  echo_len_q, echo_len_d;
  logic [sbte_pkg::LEN_W-1:0]   byte_count_q, byte_count_d;
  logic [sbte_pkg::LEN_W-1:0]   expected_q, expected_d;
  logic [sbte_pkg::LEN_W-1:0]   reply_size_q, reply_size_d;
  logic [7:0]                   sum_q, sum_d;
  logic [2:0]                   err_q, err_d;
  logic [7:0]                   dev_err_q, dev_err_d;
  logic [7:0]                   reply_low_q, reply_low_d;
  logic [7:0]                   reply_high_q, reply_high_d;
  logic [7:0]                   target_q, target_d;
  logic [DcW-1:0]               drain_q, drain_d;
  logic [3:0]                   held_line_q, held_line_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic                         out_kind_q, out_kind_d;
  logic [7:0]                   out_txv_q, out_txv_d;
  logic                         out_last_q, out_last_d;
  logic [2:0]                   out_st_q, out_st_d;
  logic [3:0]                   out_ls_q, out_ls_d;
  logic [7:0]                   out_dev_q, out_dev_d;
  logic [7:0]                   out_lo_q, out_lo_d;
  logic [7:0]                   out_hi_q, out_hi_d;
  logic [1:0]                   out_cnt_q, out_cnt_d;

  logic                         slot_free, s_acc;
  logic [IdxW-1:0]              rd_idx;
  logic [7:0]                   pkt_rd;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !tx_busy_q && slot_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // single read port: packet readout while transmitting, echo check afterwards
  assign rd_idx = tx_busy_q ? tx_idx_q : byte_count_q[IdxW-1:0];
  assign pkt_rd = pkt_q[rd_idx];

  logic                         done;
  logic [2:0]                   done_st;
  logic [3:0]                   done_ls;
  logic [sbte_pkg::ECHO_W-1:0]  req_ws;
  logic [7:0]                   req_len, req_sum;
  logic [sbte_pkg::LEN_W-1:0]   r, r_inc, bc_inc;
  logic [1:0]                   ok_cnt;

  always_comb begin
    phase_d      = phase_q;
    pkt_d        = pkt_q;
    tx_busy_d    = tx_busy_q;
    tx_idx_d     = tx_idx_q;
    echo_len_d   = echo_len_q;
    byte_count_d = byte_count_q;
    expected_d   = expected_q;
    reply_size_d = reply_size_q;
    sum_d        = sum_q;
    err_d        = err_q;
    dev_err_d    = dev_err_q;
    reply_low_d  = reply_low_q;
    reply_high_d = reply_high_q;
    target_d     = target_q;
    drain_d      = drain_q;
    held_line_d  = held_line_q;

    done    = 1'b0;
    done_st = sbte_pkg::ST_OK;
    done_ls = '0;

    req_ws  = sbte_pkg::ECHO_W'(sbte_pkg::FRAME_OVERHEAD) + {2'b00, in_argc};
    req_len = 8'd2 + {6'd0, in_argc};
    req_sum = in_id + req_len + in_instr
            + ((in_argc > 2'd0) ? in_a0 : 8'd0)
            + ((in_argc > 2'd1) ? in_a1 : 8'd0)
            + ((in_argc > 2'd2) ? in_a2 : 8'd0);

    r      = byte_count_q - {5'd0, echo_len_q};
    r_inc  = r + 9'd1;
    bc_inc = byte_count_q + 9'd1;

    if (s_acc) begin
      case (s_axis_tuser)
        sbte_pkg::OP_REQUEST: begin
          if (phase_q == PH_IDLE) begin
            for (int k = 0; k < int'(PktDepth); k++) begin
              if (k < 2) begin
                pkt_d[k] = sbte_pkg::SYNC_BYTE;
              end else if (k == 2) begin
                pkt_d[k] = in_id;
              end else if (k == 3) begin
                pkt_d[k] = req_len;
              end else if (k == 4) begin
                pkt_d[k] = in_instr;
              end else if ((k - 5) < int'(in_argc)) begin
                pkt_d[k] = arg_sel(k - 5, in_a0, in_a1, in_a2);
              end else if (k == int'(req_ws) - 1) begin
                pkt_d[k] = ~req_sum;
              end
            end
            echo_len_d = req_ws;
            if (in_id != sbte_pkg::BROADCAST_ID) begin
              reply_size_d = 9'(sbte_pkg::FRAME_OVERHEAD)
                           + ((in_instr == sbte_pkg::INSTR_READ) ? {1'b0, in_a1} : 9'd0);
            end else begin
              reply_size_d = '0;
            end
            expected_d   = {5'd0, req_ws} + reply_size_d;
            target_d     = in_id;
            byte_count_d = '0;
            sum_d        = '0;
            err_d        = sbte_pkg::ST_OK;
            dev_err_d    = '0;
            reply_low_d  = '0;
            reply_high_d = '0;
            drain_d      = '0;
            held_line_d  = '0;
            phase_d      = PH_RECV;
            tx_busy_d    = 1'b1;
            tx_idx_d     = '0;
          end
        end
        sbte_pkg::OP_RX_BYTE: begin
          if (phase_q == PH_RECV) begin
            if (byte_count_q < {5'd0, echo_len_q}) begin
              if ((byte_count_q >= 9'(PktDepth)) || (pkt_rd != in_rx)) begin
                if (err_d == sbte_pkg::ST_OK) err_d = sbte_pkg::ST_ECHO;
              end
            end else begin
              if (((r < 9'd2) && (in_rx != sbte_pkg::SYNC_BYTE)) ||
                  ((r == 9'd2) && (in_rx != target_q)) ||
                  ((r == 9'd3) && ({1'b0, in_rx} != (reply_size_q - 9'd4)))) begin
                if (err_d == sbte_pkg::ST_OK) err_d = sbte_pkg::ST_PROTOCOL;
              end
              if (r == 9'd4) dev_err_d    = in_rx;
              if (r == 9'd5) reply_low_d  = in_rx;
              if (r == 9'd6) reply_high_d = in_rx;
              if ((r >= 9'd2) && (r_inc < reply_size_q)) sum_d = sum_q + in_rx;
              if ((r_inc == reply_size_q) && (in_rx != ~sum_q)) begin
                if (err_d == sbte_pkg::ST_OK) err_d = sbte_pkg::ST_CHECKSUM;
              end
            end
            byte_count_d = bc_inc;
            if (bc_inc >= expected_q) begin
              if (err_d != sbte_pkg::ST_OK) begin
                phase_d = PH_DRAIN;
                drain_d = '0;
              end else begin
                done    = 1'b1;
                phase_d = PH_IDLE;
              end
            end
          end else if (phase_q == PH_DRAIN) begin
            drain_d = drain_q + DcW'(1);
            if (drain_d >= DcW'(DRAIN_BYTES)) begin
              done    = 1'b1;
              done_st = err_q;
              done_ls = held_line_q;
              phase_d = PH_IDLE;
            end
          end
        end
        sbte_pkg::OP_LINE: begin
          if (phase_q == PH_RECV) begin
            if (in_flags[0]) begin
              done    = 1'b1;
              done_st = sbte_pkg::ST_LINE;
              done_ls = in_flags;
              phase_d = PH_IDLE;
            end else if (in_flags != 4'd0) begin
              err_d       = sbte_pkg::ST_LINE;
              held_line_d = in_flags;
              phase_d     = PH_DRAIN;
              drain_d     = '0;
            end
          end else if (phase_q == PH_DRAIN) begin
            done    = 1'b1;
            done_st = err_q;
            done_ls = held_line_q;
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    // packet readout
    if (tx_busy_q && slot_free) begin
      tx_idx_d = tx_idx_q + IdxW'(1);
      if (tx_idx_q == IdxW'(echo_len_q - 4'd1)) tx_busy_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_txv_d   = out_txv_q;
    out_last_d  = out_last_q;
    out_st_d    = out_st_q;
    out_ls_d    = out_ls_q;
    out_dev_d   = out_dev_q;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    out_cnt_d   = out_cnt_q;

    case (reply_size_q)
      9'd7:    ok_cnt = 2'd1;
      9'd8:    ok_cnt = 2'd2;
      default: ok_cnt = 2'd0;
    endcase

    if (tx_busy_q && slot_free) begin
      out_valid_d = 1'b1;
      out_kind_d  = sbte_pkg::KIND_TX;
      out_txv_d   = pkt_rd;
      out_last_d  = (tx_idx_q == IdxW'(echo_len_q - 4'd1));
      out_st_d    = sbte_pkg::ST_OK;
      out_ls_d    = '0;
      out_dev_d   = '0;
      out_lo_d    = '0;
      out_hi_d    = '0;
      out_cnt_d   = '0;
    end else if (done) begin
      out_valid_d = 1'b1;
      out_kind_d  = sbte_pkg::KIND_DONE;
      out_txv_d   = '0;
      out_last_d  = 1'b0;
      out_st_d    = done_st;
      out_ls_d    = (done_st == sbte_pkg::ST_LINE) ? done_ls : 4'd0;
      out_dev_d   = '0;
      out_lo_d    = '0;
      out_hi_d    = '0;
      out_cnt_d   = '0;
      if (done_st == sbte_pkg::ST_OK && target_q != sbte_pkg::BROADCAST_ID) begin
        out_dev_d = dev_err_d;
        out_lo_d  = (ok_cnt != 2'd0) ? reply_low_d : 8'd0;
        out_hi_d  = (ok_cnt == 2'd2) ? reply_high_d : 8'd0;
        out_cnt_d = ok_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tx_busy_q    <= 1'b0;
      tx_idx_q     <= '0;
      echo_len_q   <= '0;
      byte_count_q <= '0;
      expected_q   <= '0;
      reply_size_q <= '0;
      sum_q        <= '0;
      err_q        <= sbte_pkg::ST_OK;
      dev_err_q    <= '0;
      reply_low_q  <= '0;
      reply_high_q <= '0;
      target_q     <= '0;
      drain_q      <= '0;
      held_line_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      tx_busy_q    <= tx_busy_d;
      tx_idx_q     <= tx_idx_d;
      echo_len_q   <= echo_len_d;
      byte_count_q <= byte_count_d;
      expected_q   <= expected_d;
      reply_size_q <= reply_size_d;
      sum_q        <= sum_d;
      err_q        <= err_d;
      dev_err_q    <= dev_err_d;
      reply_low_q  <= reply_low_d;
      reply_high_q <= reply_high_d;
      target_q     <= target_d;
      drain_q      <= drain_d;
      held_line_q  <= held_line_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q      <= pkt_d;
    out_kind_q <= out_kind_d;
    out_txv_q  <= out_txv_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
    out_ls_q   <= out_ls_d;
    out_dev_q  <= out_dev_d;
    out_lo_q   <= out_lo_d;
    out_hi_q   <= out_hi_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_cnt_q, out_hi_q, out_lo_q, out_dev_q,
                          out_ls_q, out_st_q, out_txv_q};

  // no input while the packet is being read out
  a_no_accept_in_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_busy_q |-> !s_axis_tready)
    else $error("input accepted during packet readout");

  // a request taken while idle starts the readout
  a_req_starts_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser == sbte_pkg::OP_REQUEST && phase_q == PH_IDLE) |=> tx_busy_q)
    else $error("request did not start packet readout");

  // draining always has a failure recorded
  a_drain_has_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DRAIN) |-> (err_q != sbte_pkg::ST_OK))
    else $error("drain phase without error");

  // a completion never carries end of packet
  a_done_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sbte_pkg::KIND_DONE) |-> !m_axis_tlast)
    else $error("completion marked as last packet byte");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_ARGS      = 3;
  localparam int unsigned DRAIN_BYTES   = 18;
  localparam int unsigned TARGET_ITEMS  = 380;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  // op value that the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // fault injection per transaction
  localparam int unsigned F_ECHO  = 1 << 0;
  localparam int unsigned F_SYNC  = 1 << 1;
  localparam int unsigned F_ID    = 1 << 2;
  localparam int unsigned F_LEN   = 1 << 3;
  localparam int unsigned F_SUM   = 1 << 4;
  localparam int unsigned F_LINE  = 1 << 5;
  localparam int unsigned F_CUT   = 1 << 6;
  localparam int unsigned F_STRAY = 1 << 7;

  // low 54 bits line up with s_axis_tdata, op on top is tuser
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] line_flags;
    logic [7:0] rx_value;
    logic [7:0] arg_third;
    logic [7:0] arg_second;
    logic [7:0] arg_first;
    logic [1:0] arg_count;
    logic [7:0] instruction;
    logic [7:0] servo_id;
  } bus_item_t;

  // low 41 bits line up with m_axis_tdata, then tlast, then tuser
  typedef struct packed {
    logic       kind;
    logic       tx_last;
    logic [1:0] data_count;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] device_error;
    logic [3:0] line_status;
    logic [2:0] status;
    logic [7:0] tx_value;
  } bus_result_t;

  typedef enum logic [1:0] {LINK_IDLE, LINK_RECV, LINK_DRAIN} link_phase_e;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [sbte_pkg::IN_W-1:0]     s_axis_tdata  = '0;
  logic [1:0]                    s_axis_tuser  = sbte_pkg::OP_REQUEST;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [sbte_pkg::OUT_W-1:0]    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  servo_bus_transaction_engine #(
    .MAX_ARGS   (MAX_ARGS),
    .DRAIN_BYTES(DRAIN_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  bus_item_t   pending_items [$];
  bus_result_t expected_results [$];

  int unsigned work_items     = 0;
  int unsigned txn_count      = 0;
  int unsigned pending_total  = 0;
  int unsigned accepted_items = 0;
  int unsigned stall_cycles   = 0;
  int unsigned fail_count     = 0;
  int unsigned tx_bytes       = 0;
  int unsigned done_by_status [5];
  bit          in_fire        = 1'b0;
  bit          out_fire       = 1'b0;
  bit          send_burst     = 1'b0;
  bit          recv_burst     = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned hold_gap       = 0;

  // transaction tracker state
  link_phase_e link_phase = LINK_IDLE;
  logic [7:0]  pkt_shadow [9];
  logic [8:0]  rx_count   = '0;
  logic [8:0]  total_len  = '0;
  logic [7:0]  reply_sum  = '0;
  logic [2:0]  first_fault = sbte_pkg::ST_OK;
  logic [7:0]  err_byte   = '0;
  logic [7:0]  low_byte   = '0;
  logic [7:0]  high_byte  = '0;
  logic [7:0]  dest_id    = '0;
  logic [4:0]  drained    = '0;
  logic [3:0]  held_flags = '0;

  function automatic void note_fault(input logic [2:0] code);
    if (first_fault == sbte_pkg::ST_OK) first_fault = code;
  endfunction

  function automatic void emit_completion(input logic [2:0] st, input logic [3:0] ls);
    bus_result_t r;
    int unsigned reply_len;
    logic [1:0]  cnt;
    r = '0;
    r.kind = sbte_pkg::KIND_DONE;
    link_phase = LINK_IDLE;
    if (st != sbte_pkg::ST_OK) begin
      r.status = st;
      if (st == sbte_pkg::ST_LINE) r.line_status = ls;
    end else if (dest_id != sbte_pkg::BROADCAST_ID) begin
      reply_len = total_len - (pkt_shadow[3] + 4);
      cnt = (reply_len == 7) ? 2'd1 : ((reply_len == 8) ? 2'd2 : 2'd0);
      r.device_error = err_byte;
      r.data_low     = (cnt >= 1) ? low_byte : 8'h00;
      r.data_high    = (cnt == 2) ? high_byte : 8'h00;
      r.data_count   = cnt;
    end
    expected_results.push_back(r);
  endfunction

  function automatic void predict_bus_item(input bus_item_t it);
    int unsigned echo_len, pos, r, reply_len, i;
    logic [7:0]  sum;
    logic [7:0]  args [3];
    bus_result_t tx;
    args[0] = it.arg_first;
    args[1] = it.arg_second;
    args[2] = it.arg_third;
    case (it.op)
      sbte_pkg::OP_REQUEST: begin
        if (link_phase == LINK_IDLE) begin
          echo_len = sbte_pkg::FRAME_OVERHEAD + it.arg_count;
          pkt_shadow[0] = sbte_pkg::SYNC_BYTE;
          pkt_shadow[1] = sbte_pkg::SYNC_BYTE;
          pkt_shadow[2] = it.servo_id;
          pkt_shadow[3] = 8'(2 + it.arg_count);
          pkt_shadow[4] = it.instruction;
          sum = it.servo_id + pkt_shadow[3] + it.instruction;
          for (i = 0; i < it.arg_count; i++) begin
            pkt_shadow[5 + i] = args[i];
            sum = sum + args[i];
          end
          pkt_shadow[echo_len - 1] = ~sum;
          total_len = 9'(echo_len);
          if (it.servo_id != sbte_pkg::BROADCAST_ID)
            total_len = 9'(echo_len + sbte_pkg::FRAME_OVERHEAD +
                           ((it.instruction == sbte_pkg::INSTR_READ) ?
                            it.arg_second : 8'h00));
          dest_id     = it.servo_id;
          rx_count    = '0;
          reply_sum   = '0;
          first_fault = sbte_pkg::ST_OK;
          err_byte    = '0;
          low_byte    = '0;
          high_byte   = '0;
          drained     = '0;
          held_flags  = '0;
          link_phase  = LINK_RECV;
          for (i = 0; i < echo_len; i++) begin
            tx = '0;
            tx.kind     = sbte_pkg::KIND_TX;
            tx.tx_value = pkt_shadow[i];
            tx.tx_last  = (i == echo_len - 1);
            expected_results.push_back(tx);
          end
        end
      end
      sbte_pkg::OP_RX_BYTE: begin
        if (link_phase == LINK_RECV) begin
          echo_len = pkt_shadow[3] + 4;
          pos = rx_count;
          if (pos < echo_len) begin
            if (pkt_shadow[pos] != it.rx_value) note_fault(sbte_pkg::ST_ECHO);
          end else begin
            r = pos - echo_len;
            reply_len = total_len - echo_len;
            if (r < 2 && it.rx_value != sbte_pkg::SYNC_BYTE) note_fault(sbte_pkg::ST_PROTOCOL);
            if (r == 2 && it.rx_value != dest_id) note_fault(sbte_pkg::ST_PROTOCOL);
            if (r == 3 && it.rx_value != reply_len - 4) note_fault(sbte_pkg::ST_PROTOCOL);
            if (r == 4) err_byte = it.rx_value;
            if (r == 5) low_byte = it.rx_value;
            if (r == 6) high_byte = it.rx_value;
            if (r >= 2 && r + 1 < reply_len) reply_sum = reply_sum + it.rx_value;
            if (r + 1 == reply_len && it.rx_value != ~reply_sum)
              note_fault(sbte_pkg::ST_CHECKSUM);
          end
          rx_count = 9'(pos + 1);
          if (rx_count >= total_len) begin
            if (first_fault != sbte_pkg::ST_OK) begin
              link_phase = LINK_DRAIN;
              drained = '0;
            end else begin
              emit_completion(sbte_pkg::ST_OK, 4'h0);
            end
          end
        end else if (link_phase == LINK_DRAIN) begin
          drained = drained + 5'd1;
          if (drained >= DRAIN_BYTES) emit_completion(first_fault, held_flags);
        end
      end
      sbte_pkg::OP_LINE: begin
        if (link_phase == LINK_RECV && it.line_flags != 4'h0) begin
          if (it.line_flags[0]) begin
            emit_completion(sbte_pkg::ST_LINE, it.line_flags);
          end else begin
            // a line error overrides an earlier fault
            first_fault = sbte_pkg::ST_LINE;
            held_flags  = it.line_flags;
            link_phase  = LINK_DRAIN;
            drained     = '0;
          end
        end else if (link_phase == LINK_DRAIN) begin
          emit_completion(first_fault, held_flags);
        end
      end
      default: ;
    endcase
  endfunction

  // every field random, so unused fields toggle too
  function automatic bus_item_t scrambled_item(input logic [1:0] op);
    bus_item_t it;
    it.op          = op;
    it.line_flags  = 4'($urandom);
    it.rx_value    = 8'($urandom);
    it.arg_third   = 8'($urandom);
    it.arg_second  = 8'($urandom);
    it.arg_first   = 8'($urandom);
    it.arg_count   = 2'($urandom);
    it.instruction = 8'($urandom);
    it.servo_id    = 8'($urandom);
    return it;
  endfunction

  function automatic void push_noise();
    bus_item_t it;
    case ($urandom_range(0, 2))
      0:       it = scrambled_item(sbte_pkg::OP_RX_BYTE);
      1:       it = scrambled_item(sbte_pkg::OP_LINE);
      default: it = scrambled_item(OP_UNUSED);
    endcase
    pending_items.push_back(it);
  endfunction

  // leaves the block idle whether it is receiving, draining or done
  function automatic void close_out();
    bus_item_t it;
    int unsigned k;
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < DRAIN_BYTES; k++) begin
        pending_items.push_back(scrambled_item(sbte_pkg::OP_RX_BYTE));
        work_items++;
      end
    end
    it = scrambled_item(sbte_pkg::OP_LINE);
    it.line_flags[0] = 1'b1;
    pending_items.push_back(it);
    work_items++;
  endfunction

  function automatic void run_transaction(input logic [7:0] id, input logic [7:0] instr,
                                          input logic [1:0] argc, input logic [7:0] a0,
                                          input logic [7:0] a1, input logic [7:0] a2,
                                          input int unsigned faults);
    logic [7:0]  args [3];
    logic [7:0]  octets [$];
    logic [7:0]  sum, len_byte, err, d, flip;
    int unsigned echo_len, reply_len, keep, k, at;
    bus_item_t   seq [$];
    bus_item_t   it;
    bit          need_close;
    args[0] = a0;
    args[1] = a1;
    args[2] = a2;
    it = scrambled_item(sbte_pkg::OP_REQUEST);
    it.servo_id    = id;
    it.instruction = instr;
    it.arg_count   = argc;
    it.arg_first   = a0;
    it.arg_second  = a1;
    it.arg_third   = a2;
    pending_items.push_back(it);
    work_items++;
    txn_count++;

    len_byte = 8'(2 + argc);
    sum = id + len_byte + instr;
    octets.push_back(sbte_pkg::SYNC_BYTE);
    octets.push_back(sbte_pkg::SYNC_BYTE);
    octets.push_back(id);
    octets.push_back(len_byte);
    octets.push_back(instr);
    for (k = 0; k < argc; k++) begin
      octets.push_back(args[k]);
      sum = sum + args[k];
    end
    octets.push_back(~sum);
    echo_len = octets.size();
    need_close = (faults != 0);

    if (id != sbte_pkg::BROADCAST_ID) begin
      reply_len = sbte_pkg::FRAME_OVERHEAD + ((instr == sbte_pkg::INSTR_READ) ? a1 : 8'h00);
      len_byte = 8'(reply_len - 4);
      err = 8'($urandom);
      if ($urandom_range(0, 1)) err = 8'h00;
      octets.push_back(sbte_pkg::SYNC_BYTE);
      octets.push_back(sbte_pkg::SYNC_BYTE);
      octets.push_back(id);
      octets.push_back(len_byte);
      octets.push_back(err);
      sum = id + len_byte + err;
      for (k = 0; k < reply_len - sbte_pkg::FRAME_OVERHEAD; k++) begin
        d = 8'($urandom);
        octets.push_back(d);
        sum = sum + d;
      end
      octets.push_back(~sum);
      // length byte cannot hold it: block sees a protocol error and drains
      if (reply_len - 4 > 255) need_close = 1'b1;
      flip = 8'($urandom_range(1, 255));
      at = echo_len + $urandom_range(0, 1);
      if (faults & F_SYNC) octets[at] = octets[at] ^ flip;
      at = echo_len + 2;
      if (faults & F_ID) octets[at] = octets[at] ^ flip;
      at = echo_len + 3;
      if (faults & F_LEN) octets[at] = octets[at] ^ flip;
      at = octets.size() - 1;
      if (faults & F_SUM) octets[at] = octets[at] ^ flip;
    end
    if (faults & F_ECHO) begin
      at = $urandom_range(0, echo_len - 1);
      flip = 8'($urandom_range(1, 255));
      octets[at] = octets[at] ^ flip;
    end

    keep = octets.size();
    if (faults & F_CUT) keep = $urandom_range(0, keep - 1);
    for (k = 0; k < keep; k++) begin
      it = scrambled_item(sbte_pkg::OP_RX_BYTE);
      it.rx_value = octets[k];
      seq.push_back(it);
    end
    if (faults & F_LINE) begin
      it = scrambled_item(sbte_pkg::OP_LINE);
      it.line_flags = 4'($urandom_range(0, 15));
      seq.insert($urandom_range(0, seq.size()), it);
    end
    if (faults & F_STRAY)
      seq.insert($urandom_range(0, seq.size()), scrambled_item(sbte_pkg::OP_REQUEST));
    foreach (seq[n]) pending_items.push_back(seq[n]);
    work_items += seq.size();
    if (need_close) close_out();
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic string describe(input bus_result_t r);
    return $sformatf("kind=%0d tx=%02h last=%0d st=%0d line=%h err=%02h lo=%02h hi=%02h cnt=%0d",
                     r.kind, r.tx_value, r.tx_last, r.status, r.line_status,
                     r.device_error, r.data_low, r.data_high, r.data_count);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver and ready generator
  always @(negedge clk_i) begin
    bus_item_t outgoing;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (send_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap--;
        end else if (pending_items.size() != 0) begin
          outgoing = pending_items.pop_front();
          s_axis_tuser  <= outgoing.op;
          s_axis_tdata  <= {2'b00, outgoing[53:0]};
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          send_gap = draw_wait(send_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        hold_gap = draw_wait(recv_burst);
      end
      if (hold_gap > 0) begin
        m_axis_tready <= 1'b0;
        hold_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: results are checked before the item taken at the same edge is predicted
  always @(posedge clk_i) begin
    bus_result_t got, want;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (!rst_ni || in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
    if (out_fire) begin
      got = {m_axis_tuser, m_axis_tlast, m_axis_tdata[40:0]};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected item %s", $realtime, describe(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch, expected %s", $realtime, describe(want));
            $display("%0t:           actual   %s", $realtime, describe(got));
          end
        end
        if (want.kind == sbte_pkg::KIND_TX) tx_bytes++;
        else done_by_status[want.status]++;
      end
    end
    if (in_fire) begin
      predict_bus_item({s_axis_tuser, s_axis_tdata[53:0]});
      accepted_items++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0]  id, instr, a1;
    int unsigned faults, k;

    // ignored while idle: a byte, a line event and an undefined op
    pending_items.push_back(scrambled_item(sbte_pkg::OP_RX_BYTE));
    pending_items.push_back(scrambled_item(sbte_pkg::OP_LINE));
    pending_items.push_back(scrambled_item(OP_UNUSED));
    // broadcast with the widest packet, no reply
    run_transaction(sbte_pkg::BROADCAST_ID, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 0);
    // read of one byte, then two bytes with the length taken from an unsent argument
    run_transaction(8'h00, sbte_pkg::INSTR_READ, 2'd2, 8'h00, 8'h01, 8'h00, 0);
    run_transaction(8'hFF, sbte_pkg::INSTR_READ, 2'd0, 8'h24, 8'h02, 8'h00, 0);
    // echo fault outranks a checksum fault
    run_transaction(8'h05, 8'h03, 2'd1, 8'h1E, 8'h00, 8'h00, F_ECHO | F_SUM);
    // line event during the exchange
    run_transaction(8'h07, sbte_pkg::INSTR_READ, 2'd2, 8'h24, 8'h02, 8'h00, F_LINE);

    while (work_items < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    id = sbte_pkg::BROADCAST_ID;
        2:       id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: id = 8'($urandom);
      endcase
      instr = $urandom_range(0, 1) ? sbte_pkg::INSTR_READ : 8'($urandom);
      k = $urandom_range(0, 99);
      if (k < 80) a1 = 8'($urandom_range(0, 4));
      else if (k < 96) a1 = 8'($urandom_range(5, 16));
      else a1 = 8'($urandom_range(240, 255));
      faults = 0;
      if ($urandom_range(0, 9) >= 6) begin
        faults = 1 << $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) faults = faults | (1 << $urandom_range(0, 7));
      end
      run_transaction(id, instr, 2'($urandom), 8'($urandom), a1, 8'($urandom), faults);
      if ($urandom_range(0, 4) == 0)
        for (k = $urandom_range(1, 3); k > 0; k--) push_noise();
    end
    pending_total = pending_items.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items != pending_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d expected items never arrived", expected_results.size());
    end

    $display("%0d items in, %0d transactions, %0d packet bytes out, %0d mismatches",
             accepted_items, txn_count, tx_bytes, fail_count);
    $display("completions: ok %0d, line %0d, echo %0d, protocol %0d, checksum %0d",
             done_by_status[sbte_pkg::ST_OK], done_by_status[sbte_pkg::ST_LINE],
             done_by_status[sbte_pkg::ST_ECHO], done_by_status[sbte_pkg::ST_PROTOCOL],
             done_by_status[sbte_pkg::ST_CHECKSUM]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
